>>> rtl/core/array_linked_list_engine_macros.svh
// Assertion helpers for the checker in ale_checker.sv.
`ifndef ARRAY_LINKED_LIST_ENGINE_MACROS_SVH
`define ARRAY_LINKED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ALE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ALE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ale_pkg.sv
package ale_pkg;

	localparam int VAL_W  = 32;
	localparam int LINK_W = 7;
	localparam logic [LINK_W-1:0] NULL_LINK = '1;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_INSERT,
		OP_REMOVE,
		OP_LIST
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_NOT_FOUND,
		ST_EMPTY
	} status_t;

	typedef struct packed {
		op_t                     operation;
		logic signed [VAL_W-1:0] item_value;
	} in_item_t;

	typedef struct packed {
		status_t                 status;
		logic signed [VAL_W-1:0] out_value;
		logic                    last;
	} out_item_t;

	typedef enum logic {
		S_IDLE,
		S_WALK
	} state_t;

endpackage

>>> rtl/core/ale_ram.sv
module ale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/array_linked_list_engine.sv
// Linked-list engine: one singly linked list of 32-bit signed values kept in a node store
// of CAPACITY entries (a value memory and a link memory, both with a registered read). An
// item is accepted when start is high and busy is low; each result appears on result for
// exactly one cycle with strobe high, and the receiver cannot stall it, so capture every
// strobed cycle. Clear, an insert into a full store, and an insert, remove or list on an
// empty list answer in the cycle after acceptance and keep busy low. Every other item
// chases the chain through the link memory at one node per cycle: an insert walks up to
// and including the tail, a remove up to the match (or the whole list when nothing
// matches), and a list walks every node while it emits one result per cycle. The last
// result of every item carries last = 1 and leaves the cycle busy drops. Removed nodes
// are not reclaimed: only a clear or a reset returns the allocator to slot zero, so an
// insert can be refused as full while the list is short. No clearing pass runs after
// reset; the block takes items immediately.
module array_linked_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ale_pkg::in_item_t cmd,
	output logic              strobe,
	output ale_pkg::out_item_t result
);

	import ale_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [LINK_W-1:0] CAP_LINK  = LINK_W'(CAPACITY);
	localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(CAPACITY - 1);

	// control state
	state_t             state_q, state_d;
	logic [LINK_W-1:0]  head_q, head_d;
	logic [CNT_W-1:0]   free_q, free_d;
	logic [CNT_W-1:0]   steps_q, steps_d;
	logic               strobe_q, strobe_d;

	// walk payload
	op_t                     op_q, op_d;
	logic signed [VAL_W-1:0] val_q, val_d;
	logic [LINK_W-1:0]       cur_q, cur_d;
	logic [LINK_W-1:0]       prev_q, prev_d;
	logic [IDX_W-1:0]        slot_q, slot_d;
	out_item_t               result_q, result_d;

	// node store ports
	logic                    val_we;
	logic [IDX_W-1:0]        val_waddr;
	logic [VAL_W-1:0]        val_wdata;
	logic                    lnk_we;
	logic [IDX_W-1:0]        lnk_waddr;
	logic [LINK_W-1:0]       lnk_wdata;
	logic [IDX_W-1:0]        rd_addr;
	logic [VAL_W-1:0]        val_rd;
	logic [LINK_W-1:0]       lnk_rd;

	logic accept;
	logic head_node;
	logic nxt_node;
	logic cur_hit;
	logic at_bound;

	// Both memories are read at the same address: the node under inspection.
	ale_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (rd_addr),
		.rdata (val_rd)
	);

	ale_ram #(
		.WIDTH (LINK_W),
		.DEPTH (CAPACITY)
	) u_lnk_ram (
		.clk   (clk),
		.we    (lnk_we),
		.waddr (lnk_waddr),
		.wdata (lnk_wdata),
		.raddr (rd_addr),
		.rdata (lnk_rd)
	);

	assign accept    = start && !busy;
	assign head_node = head_q < CAP_LINK;
	// A link at or above CAPACITY is null.
	assign nxt_node  = lnk_rd < CAP_LINK;
	assign cur_hit   = $signed(val_rd) == val_q;
	// Remove and list visit at most CAPACITY nodes.
	assign at_bound  = steps_q == LAST_STEP;

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		free_d    = free_q;
		steps_d   = steps_q;
		strobe_d  = 1'b0;
		op_d      = op_q;
		val_d     = val_q;
		cur_d     = cur_q;
		prev_d    = prev_q;
		slot_d    = slot_q;
		result_d  = result_q;
		val_we    = 1'b0;
		val_waddr = free_q[IDX_W-1:0];
		val_wdata = cmd.item_value;
		lnk_we    = 1'b0;
		lnk_waddr = free_q[IDX_W-1:0];
		lnk_wdata = NULL_LINK;
		// Idle: prefetch the head node so a walk starts with its data in hand.
		rd_addr   = head_q[IDX_W-1:0];

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_d     = cmd.operation;
					val_d    = cmd.item_value;
					cur_d    = head_q;
					prev_d   = NULL_LINK;
					steps_d  = '0;
					result_d = '{status: ST_OK, out_value: '0, last: 1'b1};
					case (cmd.operation)
						OP_CLEAR: begin
							head_d   = NULL_LINK;
							free_d   = '0;
							strobe_d = 1'b1;
						end
						OP_INSERT: begin
							if (free_q == CAP_CNT) begin
								result_d.status = ST_FULL;
								strobe_d        = 1'b1;
							end else begin
								// Fill the new slot now; link it once the tail is found.
								val_we = 1'b1;
								lnk_we = 1'b1;
								free_d = free_q + 1'b1;
								slot_d = free_q[IDX_W-1:0];
								if (!head_node) begin
									head_d   = LINK_W'(free_q);
									strobe_d = 1'b1;
								end else begin
									state_d = S_WALK;
								end
							end
						end
						OP_REMOVE: begin
							if (!head_node) begin
								result_d.status = ST_NOT_FOUND;
								strobe_d        = 1'b1;
							end else begin
								state_d = S_WALK;
							end
						end
						default: begin
							if (!head_node) begin
								result_d.status = ST_EMPTY;
								strobe_d        = 1'b1;
							end else begin
								state_d = S_WALK;
							end
						end
					endcase
				end
			end

			S_WALK: begin
				// Chase the link: fetch the successor while inspecting this node.
				rd_addr = lnk_rd[IDX_W-1:0];
				case (op_q)
					OP_INSERT: begin
						if (steps_q == CAP_CNT || !nxt_node) begin
							lnk_we    = 1'b1;
							lnk_waddr = cur_q[IDX_W-1:0];
							lnk_wdata = LINK_W'(slot_q);
							result_d  = '{status: ST_OK, out_value: '0, last: 1'b1};
							strobe_d  = 1'b1;
							state_d   = S_IDLE;
						end else begin
							cur_d   = lnk_rd;
							steps_d = steps_q + 1'b1;
						end
					end
					OP_REMOVE: begin
						if (cur_hit) begin
							// Unlink: predecessor or head takes this node's successor.
							if (prev_q < CAP_LINK) begin
								lnk_we    = 1'b1;
								lnk_waddr = prev_q[IDX_W-1:0];
								lnk_wdata = lnk_rd;
							end else begin
								head_d = lnk_rd;
							end
							result_d = '{status: ST_OK, out_value: '0, last: 1'b1};
							strobe_d = 1'b1;
							state_d  = S_IDLE;
						end else if (!nxt_node || at_bound) begin
							result_d = '{status: ST_NOT_FOUND, out_value: '0, last: 1'b1};
							strobe_d = 1'b1;
							state_d  = S_IDLE;
						end else begin
							prev_d  = cur_q;
							cur_d   = lnk_rd;
							steps_d = steps_q + 1'b1;
						end
					end
					default: begin
						// Emit one node per cycle.
						result_d = '{status: ST_OK, out_value: $signed(val_rd),
							last: !nxt_node || at_bound};
						strobe_d = 1'b1;
						if (!nxt_node || at_bound) begin
							state_d = S_IDLE;
						end else begin
							cur_d   = lnk_rd;
							steps_d = steps_q + 1'b1;
						end
					end
				endcase
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= NULL_LINK;
			free_q   <= '0;
			steps_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			free_q   <= free_d;
			steps_q  <= steps_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		val_q    <= val_d;
		cur_q    <= cur_d;
		prev_q   <= prev_d;
		slot_q   <= slot_d;
		result_q <= result_d;
	end

	assign busy   = state_q != S_IDLE;
	assign strobe = strobe_q;
	assign result = result_q;

endmodule

>>> rtl/core/ale_checker.sv
`include "array_linked_list_engine_macros.svh"

module ale_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input ale_pkg::in_item_t  cmd,
	input logic               strobe,
	input ale_pkg::out_item_t result
);

	import ale_pkg::*;

	`ALE_ASSERT_NXT(a_clear_answers, start && !busy && cmd.operation == OP_CLEAR, strobe && result.last && result.status == ST_OK && !busy, "clear must answer ok next cycle")
	`ALE_ASSERT_IMP(a_walk_ends_last, $fell(busy), strobe && result.last, "end of a walk must deliver the last result")
	`ALE_ASSERT_IMP(a_mid_list_busy, strobe && !result.last, busy, "non-final result while idle")
	`ALE_ASSERT_IMP(a_status_only, strobe && result.status != ST_OK, result.last && result.out_value == 0, "error status must be a single zero-valued result")

endmodule

bind array_linked_list_engine ale_checker u_ale_checker (.*);

>>> dv/ale_list_checker.sv
`timescale 1ns / 1ps

module ale_list_checker #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  ale_pkg::in_item_t  cmd,
	input  logic               strobe,
	input  ale_pkg::out_item_t result,
	output int                 mismatches,
	output int                 awaited
);
	import ale_pkg::*;

	// Shadow copy of the node store and its pointers
	logic signed [VAL_W-1:0]  node_value [CAPACITY];
	logic        [LINK_W-1:0] node_link  [CAPACITY];
	logic        [LINK_W-1:0] head_ptr;
	logic        [LINK_W-1:0] free_slot;

	// Result items still owed by the block, oldest first
	out_item_t awaited_results [$];

	function automatic logic is_node(logic [LINK_W-1:0] link);
		return int'(link) < CAPACITY;
	endfunction

	task automatic queue_status(status_t st);
		out_item_t r;
		r.status    = st;
		r.out_value = '0;
		r.last      = 1'b1;
		awaited_results.push_back(r);
	endtask

	// Apply one accepted item to the shadow list and queue what it must answer.
	task automatic apply_list_command(in_item_t c);
		logic [LINK_W-1:0] cur;
		logic [LINK_W-1:0] prev;
		logic [LINK_W-1:0] nxt;
		logic [LINK_W-1:0] slot;
		logic              found;
		int                steps;
		int                n;
		out_item_t         r;
		case (c.operation)
			OP_CLEAR: begin
				head_ptr  = NULL_LINK;
				free_slot = '0;
				queue_status(ST_OK);
			end
			OP_INSERT: begin
				if (int'(free_slot) >= CAPACITY) begin
					queue_status(ST_FULL);
				end else begin
					slot             = free_slot;
					node_value[slot] = c.item_value;
					node_link[slot]  = NULL_LINK;
					free_slot        = free_slot + 1'b1;
					if (!is_node(head_ptr)) begin
						head_ptr = slot;
					end else begin
						cur = head_ptr;
						for (steps = 0; steps < CAPACITY; steps++) begin
							if (!is_node(node_link[cur]))
								break;
							cur = node_link[cur];
						end
						node_link[cur] = slot;
					end
					queue_status(ST_OK);
				end
			end
			OP_REMOVE: begin
				cur   = head_ptr;
				prev  = NULL_LINK;
				found = 1'b0;
				for (steps = 0; steps < CAPACITY && !found && is_node(cur); steps++) begin
					if (node_value[cur] == c.item_value) begin
						if (is_node(prev))
							node_link[prev] = node_link[cur];
						else
							head_ptr = node_link[cur];
						found = 1'b1;
					end else begin
						prev = cur;
						cur  = node_link[cur];
					end
				end
				queue_status(found ? ST_OK : ST_NOT_FOUND);
			end
			OP_LIST: begin
				if (!is_node(head_ptr)) begin
					queue_status(ST_EMPTY);
				end else begin
					cur = head_ptr;
					n   = 0;
					while (n < CAPACITY && is_node(cur)) begin
						nxt         = node_link[cur];
						n++;
						r.status    = ST_OK;
						r.out_value = node_value[cur];
						r.last      = (n >= CAPACITY) || !is_node(nxt);
						awaited_results.push_back(r);
						cur = nxt;
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				node_value[i] = '0;
				node_link[i]  = '0;
			end
			head_ptr  = NULL_LINK;
			free_slot = '0;
			awaited_results.delete();
			mismatches = 0;
		end else begin
			// Check the strobed result first: an item accepted at this edge answers later.
			if (strobe) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result: expected none, actual status %0d value %0d last %0b",
						$time, result.status, result.out_value, result.last);
				end else begin
					want = awaited_results.pop_front();
					if (result.status !== want.status) begin
						mismatches++;
						$display("%0t: status: expected %0d, actual %0d",
							$time, want.status, result.status);
					end
					if (result.out_value !== want.out_value) begin
						mismatches++;
						$display("%0t: out_value: expected %0d, actual %0d",
							$time, want.out_value, result.out_value);
					end
					if (result.last !== want.last) begin
						mismatches++;
						$display("%0t: last: expected %0b, actual %0b",
							$time, want.last, result.last);
					end
				end
			end
			if (start && !busy)
				apply_list_command(cmd);
		end
		awaited = awaited_results.size();
	end

endmodule

>>> dv/tb_array_linked_list_engine.sv
`timescale 1ns / 1ps

module tb_array_linked_list_engine;
	import ale_pkg::*;

	localparam int CAPACITY    = 64;
	// Upper bound on the run length in clock cycles, for the watchdog.
	localparam int CYCLE_LIMIT = 400000;
	// Random items per phase, on top of the directed opening.
	localparam int PHASE_ITEMS = 150;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  cmd;
	logic      strobe;
	out_item_t result;

	int mismatch_count;
	int awaited_count;
	int cycle_count;
	int items_sent;
	int idle_pct;

	// Values of the current fill, kept so the drain can remove exactly what went in
	logic signed [VAL_W-1:0] fill_values [CAPACITY];

	array_linked_list_engine #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.strobe(strobe),
		.result(result)
	);

	ale_list_checker #(
		.CAPACITY(CAPACITY)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.strobe    (strobe),
		.result    (result),
		.mismatches(mismatch_count),
		.awaited   (awaited_count)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: end the run if the block stops answering.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Drop start for a random stretch, one cycle at a time, at the current idle rate.
	task automatic hold_off_sender();
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct);
		end
	endtask

	// Present one item and hold it until an edge sees start high with busy low.
	task automatic issue(op_t op, logic signed [VAL_W-1:0] value);
		in_item_t item;
		hold_off_sender();
		item.operation  = op;
		item.item_value = value;
		start <= 1'b1;
		cmd   <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	// Mostly a small pool so removes find their target, plus extremes and full-range noise.
	function automatic logic signed [VAL_W-1:0] pick_value();
		logic signed [VAL_W-1:0] v;
		int unsigned             roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) begin
			v = $urandom_range(0, 4);
			v = v - 2;
		end else if (roll < 60) begin
			case ($urandom_range(0, 3))
				0:       v = 32'h7FFF_FFFF;
				1:       v = 32'h8000_0000;
				2:       v = '1;
				default: v = '0;
			endcase
		end else begin
			v = $urandom;
		end
		return v;
	endfunction

	// Fill the store to capacity, bounce off the full store, then unlink drain_count nodes
	// in a scattered order; the allocator keeps the store full even once the list is short.
	task automatic fill_and_drain(int drain_count);
		int offset;
		int stride;
		issue(OP_CLEAR, $urandom);
		for (int i = 0; i < CAPACITY; i++) begin
			fill_values[i] = pick_value();
			issue(OP_INSERT, fill_values[i]);
		end
		issue(OP_INSERT, pick_value());
		issue(OP_LIST, $urandom);
		// An odd stride walks every index once, so head, middle and tail all get hit.
		offset = $urandom_range(0, CAPACITY - 1);
		stride = 2 * $urandom_range(0, CAPACITY / 2 - 1) + 1;
		for (int k = 0; k < drain_count; k++)
			issue(OP_REMOVE, fill_values[(offset + k * stride) % CAPACITY]);
		issue(OP_INSERT, pick_value());
		issue(OP_LIST, $urandom);
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		items_sent = 0;
		idle_pct   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: empty list, extremes, head/middle/tail removal, duplicates.
		issue(OP_LIST, 32'h5A5A_5A5A);
		issue(OP_REMOVE, 32'sd0);
		issue(OP_INSERT, 32'h7FFF_FFFF);
		issue(OP_INSERT, 32'h8000_0000);
		issue(OP_INSERT, 32'sd0);
		issue(OP_INSERT, -32'sd1);
		issue(OP_INSERT, 32'sd1);
		issue(OP_LIST, 32'h0);
		issue(OP_REMOVE, 32'sd0);
		issue(OP_REMOVE, 32'h7FFF_FFFF);
		issue(OP_REMOVE, 32'sd1);
		issue(OP_REMOVE, 32'sd12345);
		issue(OP_LIST, 32'hFFFF_FFFF);
		issue(OP_INSERT, 32'sd5);
		issue(OP_INSERT, 32'sd5);
		issue(OP_REMOVE, 32'sd5);
		issue(OP_LIST, 32'h0);
		issue(OP_CLEAR, 32'hFFFF_FFFF);
		issue(OP_LIST, 32'h0);
		issue(OP_INSERT, 32'sd7);
		issue(OP_LIST, 32'h0);
		issue(OP_REMOVE, 32'sd7);
		issue(OP_LIST, 32'h0);

		// Three phases: sender idles 35%, then 57%, then back to back.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       idle_pct = 35;
				1:       idle_pct = 57;
				default: idle_pct = 0;
			endcase
			// First phase drains everything: full store with an empty list.
			fill_and_drain(phase == 0 ? CAPACITY : $urandom_range(1, 8));
			while (items_sent < 25 + (phase + 1) * PHASE_ITEMS) begin
				case ($urandom_range(0, 9))
					0: begin
						issue(OP_CLEAR, $urandom);
						repeat ($urandom_range(1, 6))
							issue(OP_INSERT, pick_value());
					end
					1, 2: begin
						repeat ($urandom_range(1, 4))
							issue(OP_INSERT, pick_value());
					end
					3, 4: begin
						repeat ($urandom_range(1, 3))
							issue(OP_REMOVE, pick_value());
					end
					5, 6: issue(OP_LIST, $urandom);
					7: issue(op_t'($urandom_range(0, 3)), $urandom);
					8: begin
						issue(OP_REMOVE, pick_value());
						issue(OP_LIST, $urandom);
					end
					default: begin
						issue(OP_INSERT, pick_value());
						issue(OP_LIST, $urandom);
					end
				endcase
			end
		end
		start <= 1'b0;

		// Drain: sample on the falling edge so the checker's counts have settled.
		while (awaited_count != 0)
			@(negedge clk);
		repeat (CAPACITY + 4) @(negedge clk);

		if (mismatch_count == 0 && awaited_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
